>>> sv/lah_pkg.sv
// Package for the latency histogram aggregator: codes, beat structs,
// saturating adders and the bin value table. No dependencies.
package lah_pkg;

  localparam int NUM_ENTRIES_DEF   = 64;
  localparam int NUM_TAIL_BINS_DEF = 28;

  localparam logic [1:0] ACT_SINGLE = 2'd0;
  localparam logic [1:0] ACT_BATCH  = 2'd1;
  localparam logic [1:0] ACT_DRAIN  = 2'd2;

  localparam logic [1:0] KIND_TOTALS = 2'd0;
  localparam logic [1:0] KIND_BIN    = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  // floor(x / 1000) = (x * RECIP_MS) >> 38 for every 32-bit x.
  localparam logic [28:0] RECIP_MS = 29'd274877907;
  // n / 5 and n / 25 for the narrow offsets inside a bin segment.
  localparam logic [12:0] RECIP_5   = 13'd205;
  localparam logic [12:0] RECIP_25S = 13'd41;
  localparam logic [12:0] RECIP_25L = 13'd5243;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  entry;
    logic [31:0] duration_us;
    logic        success;
    logic [15:0] batch_count;
    logic [15:0] batch_errors;
    logic [31:0] batch_sum_ms;
  } lah_in_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [5:0]  out_entry;
    logic [31:0] total_count;
    logic [31:0] total_errors;
    logic [47:0] total_ms;
    logic [19:0] bucket_ms;
    logic [31:0] bucket_count;
    logic        last;
  } lah_out_t;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] errors;
    logic [47:0] ms;
  } lah_ent_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_SEG, ST_QUO, ST_ADR, ST_RD, ST_WR,
    ST_DBASE, ST_BISSUE, ST_BCHK, ST_EISSUE, ST_ECHK, ST_DOUT
  } lah_state_t;

  function automatic logic [31:0] sat32_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [47:0] sat48_add(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + 49'(b);
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  // Lower edge of the bin with index i, in milliseconds.
  function automatic logic [19:0] bin_value(input logic [10:0] i);
    logic [19:0] w;
    w = 20'(i);
    if (i < 11'd19) return w + 20'd1;
    else if (i < 11'd55) return 20'd20 + (w - 20'd19) * 20'd5;
    else if (i < 11'd70) return 20'd200 + (w - 20'd55) * 20'd20;
    else if (i < 11'd100) return 20'd500 + (w - 20'd70) * 20'd50;
    else return 20'd2000 + (w - 20'd100) * 20'd200;
  endfunction

endpackage

>>> sv/latency_histogram_aggregator.sv
// Latency histogram aggregator top level: sequencer, shared multiplier,
// entry totals memory and bin memory. Depends on lah_pkg.
//
//   channel  ports                        beat taken when
//   input    start, busy, in_data         start high and busy low
//   result   out_valid, out_data          out_valid high (one cycle)
//
// Single record: divide, segment, quotient, address, read, write.
// Batch record: the same steps without the divide. Drain: each entry and
// each bin scanned is read and then checked, all on one multiplier and one
// read and one write port of each memory. After reset the bin memory and
// the entry totals memory are swept clear with busy high. A result is shown
// for exactly one cycle and is never held off by the receiver.
module latency_histogram_aggregator
  import lah_pkg::*;
#(
  parameter int NUM_ENTRIES   = NUM_ENTRIES_DEF,
  parameter int NUM_TAIL_BINS = NUM_TAIL_BINS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  lah_in_t  in_data,
  output logic     out_valid,
  output lah_out_t out_data
);

  localparam int BPE   = 100 + NUM_TAIL_BINS;
  localparam int TOTAL = NUM_ENTRIES * BPE;
  localparam int EW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int BW    = $clog2(BPE);
  localparam int AW    = $clog2(TOTAL);
  localparam logic [32:0] TAIL_SPAN = 33'(200 * NUM_TAIL_BINS);

  lah_ent_t    ent_mem [NUM_ENTRIES];
  logic [31:0] bin_mem [TOTAL];

  lah_state_t  state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [EW:0]   ecur_r, ecur_nxt;
  logic [BW:0]   bcur_r, bcur_nxt;
  logic          hdr_r, hdr_nxt;

  lah_in_t       in_r, in_nxt;
  logic [31:0]   ms_r, ms_nxt;
  logic [14:0]   n_r, n_nxt;
  logic [12:0]   recip_r, recip_nxt;
  logic          sh17_r, sh17_nxt;
  logic          direct_r, direct_nxt;
  logic [6:0]    baseb_r, baseb_nxt;
  logic [BW-1:0] bin_r, bin_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [BW:0]   bi_r, bi_nxt;
  logic [EW:0]   ei_r, ei_nxt;
  logic          look_r, look_nxt;
  lah_out_t      res_r, res_nxt;

  logic [31:0]   mul_a;
  logic [28:0]   mul_b;
  logic [60:0]   prod;
  logic [60:0]   quo;
  logic [32:0]   tail_d;

  logic [EW-1:0] rec_idx, ent_ra, ent_wa;
  logic          ent_we;
  lah_ent_t      ent_wd, ent_rd_r;
  logic [AW-1:0] bin_ra, bin_wa;
  logic          bin_we;
  logic [31:0]   bin_wd, bin_rd_r;

  logic          is_single;

  assign prod      = 61'(mul_a) * 61'(mul_b);
  assign rec_idx   = EW'(in_r.entry);
  assign is_single = (in_r.action == ACT_SINGLE);
  assign quo       = sh17_r ? (prod >> 17) : (prod >> 10);
  assign tail_d    = {1'b0, ms_r} - 33'd2000;

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    ent_rd_r <= ent_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (bin_we) bin_mem[bin_wa] <= bin_wd;
    bin_rd_r <= bin_mem[bin_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      ecur_r  <= '0;
      bcur_r  <= '0;
      hdr_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ecur_r  <= ecur_nxt;
      bcur_r  <= bcur_nxt;
      hdr_r   <= hdr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r     <= in_nxt;
    ms_r     <= ms_nxt;
    n_r      <= n_nxt;
    recip_r  <= recip_nxt;
    sh17_r   <= sh17_nxt;
    direct_r <= direct_nxt;
    baseb_r  <= baseb_nxt;
    bin_r    <= bin_nxt;
    addr_r   <= addr_nxt;
    base_r   <= base_nxt;
    bi_r     <= bi_nxt;
    ei_r     <= ei_nxt;
    look_r   <= look_nxt;
    res_r    <= res_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    ecur_nxt   = ecur_r;
    bcur_nxt   = bcur_r;
    hdr_nxt    = hdr_r;
    in_nxt     = in_r;
    ms_nxt     = ms_r;
    n_nxt      = n_r;
    recip_nxt  = recip_r;
    sh17_nxt   = sh17_r;
    direct_nxt = direct_r;
    baseb_nxt  = baseb_r;
    bin_nxt    = bin_r;
    addr_nxt   = addr_r;
    base_nxt   = base_r;
    bi_nxt     = bi_r;
    ei_nxt     = ei_r;
    look_nxt   = look_r;
    res_nxt    = res_r;
    mul_a      = '0;
    mul_b      = '0;
    ent_ra     = rec_idx;
    ent_we     = 1'b0;
    ent_wa     = rec_idx;
    ent_wd     = '0;
    bin_ra     = addr_r;
    bin_we     = 1'b0;
    bin_wa     = addr_r;
    bin_wd     = '0;

    unique case (state_r)
      ST_CLEAR: begin
        bin_we = 1'b1;
        bin_wa = clr_r;
        if (32'(clr_r) < NUM_ENTRIES) begin
          ent_we = 1'b1;
          ent_wa = EW'(clr_r);
        end
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(TOTAL - 1)) state_nxt = ST_IDLE;
      end

      ST_IDLE: begin
        if (start) begin
          in_nxt = in_data;
          priority if (in_data.action == ACT_DRAIN) begin
            res_nxt  = '0;
            look_nxt = 1'b0;
            if (hdr_r && (ecur_r < (EW+1)'(NUM_ENTRIES))) begin
              bi_nxt    = bcur_r;
              state_nxt = ST_DBASE;
            end else begin
              hdr_nxt   = 1'b0;
              ei_nxt    = ecur_r;
              state_nxt = ST_EISSUE;
            end
          end else if (32'(in_data.entry) >= NUM_ENTRIES) begin
            state_nxt = ST_IDLE;
          end else if (in_data.action == ACT_SINGLE) begin
            state_nxt = ST_DIV;
          end else if (in_data.action == ACT_BATCH) begin
            ms_nxt    = in_data.batch_sum_ms;
            state_nxt = ST_SEG;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_DIV: begin
        mul_a     = in_r.duration_us;
        mul_b     = RECIP_MS;
        ms_nxt    = 32'(prod >> 38);
        state_nxt = ST_SEG;
      end

      // Pick the bin segment; the division inside it runs next cycle.
      ST_SEG: begin
        direct_nxt = 1'b0;
        sh17_nxt   = 1'b0;
        recip_nxt  = RECIP_5;
        baseb_nxt  = 7'd0;
        n_nxt      = '0;
        bin_nxt    = '0;
        priority if (ms_r == 32'd0) begin
          direct_nxt = 1'b1;
        end else if (ms_r < 32'd20) begin
          direct_nxt = 1'b1;
          bin_nxt    = BW'(ms_r - 32'd1);
        end else if (ms_r < 32'd200) begin
          n_nxt     = 15'(ms_r - 32'd20);
          baseb_nxt = 7'd19;
        end else if (ms_r < 32'd500) begin
          n_nxt     = 15'((ms_r - 32'd200) >> 2);
          baseb_nxt = 7'd55;
        end else if (ms_r < 32'd2000) begin
          n_nxt     = 15'((ms_r - 32'd500) >> 1);
          recip_nxt = RECIP_25S;
          baseb_nxt = 7'd70;
        end else if (tail_d >= TAIL_SPAN) begin
          direct_nxt = 1'b1;
          bin_nxt    = BW'(BPE - 1);
        end else begin
          n_nxt     = 15'(tail_d >> 3);
          recip_nxt = RECIP_25L;
          sh17_nxt  = 1'b1;
          baseb_nxt = 7'd100;
        end
        state_nxt = ST_QUO;
      end

      ST_QUO: begin
        mul_a = 32'(n_r);
        mul_b = 29'(recip_r);
        if (!direct_r) bin_nxt = BW'(baseb_r) + BW'(quo);
        state_nxt = ST_ADR;
      end

      ST_ADR: begin
        mul_a     = 32'(rec_idx);
        mul_b     = 29'(BPE);
        addr_nxt  = AW'(prod) + AW'(bin_r);
        state_nxt = ST_RD;
      end

      ST_RD: begin
        state_nxt = ST_WR;
      end

      ST_WR: begin
        ent_we = 1'b1;
        if (is_single) begin
          ent_wd.count  = sat32_add(ent_rd_r.count, 32'd1);
          ent_wd.errors = sat32_add(ent_rd_r.errors, {31'd0, ~in_r.success});
        end else begin
          ent_wd.count  = sat32_add(ent_rd_r.count, 32'(in_r.batch_count));
          ent_wd.errors = sat32_add(ent_rd_r.errors, 32'(in_r.batch_errors));
        end
        ent_wd.ms = sat48_add(ent_rd_r.ms, ms_r);
        if (is_single || (in_r.batch_count == 16'd1)) begin
          bin_we = 1'b1;
          bin_wd = sat32_add(bin_rd_r, 32'd1);
        end
        state_nxt = ST_IDLE;
      end

      ST_DBASE: begin
        mul_a     = 32'(ecur_r);
        mul_b     = 29'(BPE);
        base_nxt  = AW'(prod);
        state_nxt = ST_BISSUE;
      end

      ST_BISSUE: begin
        bin_ra = base_r + AW'(bi_r);
        if (bi_r >= (BW+1)'(BPE)) begin
          // Entry has no bins left: step to the next entry.
          hdr_nxt   = 1'b0;
          ecur_nxt  = ecur_r + (EW+1)'(1);
          bcur_nxt  = '0;
          ei_nxt    = ecur_r + (EW+1)'(1);
          state_nxt = ST_EISSUE;
        end else begin
          state_nxt = ST_BCHK;
        end
      end

      ST_BCHK: begin
        bin_ra = base_r + AW'(bi_r);
        bin_wa = base_r + AW'(bi_r);
        if (bin_rd_r != 32'd0) begin
          if (!look_r) begin
            res_nxt.record_kind  = KIND_BIN;
            res_nxt.out_entry    = 6'(ecur_r);
            res_nxt.bucket_ms    = bin_value(11'(bi_r));
            res_nxt.bucket_count = bin_rd_r;
            bin_we    = 1'b1;
            bcur_nxt  = bi_r + (BW+1)'(1);
            bi_nxt    = bi_r + (BW+1)'(1);
            look_nxt  = 1'b1;
            state_nxt = ST_BISSUE;
          end else begin
            state_nxt = ST_DOUT;
          end
        end else begin
          bi_nxt    = bi_r + (BW+1)'(1);
          state_nxt = ST_BISSUE;
        end
      end

      ST_EISSUE: begin
        ent_ra = EW'(ei_r);
        if (ei_r >= (EW+1)'(NUM_ENTRIES)) begin
          if (!look_r) begin
            res_nxt             = '0;
            res_nxt.record_kind = KIND_DONE;
            hdr_nxt             = 1'b0;
          end
          res_nxt.last = 1'b1;
          ecur_nxt     = '0;
          bcur_nxt     = '0;
          state_nxt    = ST_DOUT;
        end else begin
          state_nxt = ST_ECHK;
        end
      end

      ST_ECHK: begin
        ent_ra = EW'(ei_r);
        ent_wa = EW'(ei_r);
        if (ent_rd_r.count != 32'd0) begin
          if (!look_r) begin
            res_nxt.record_kind  = KIND_TOTALS;
            res_nxt.out_entry    = 6'(ei_r);
            res_nxt.total_count  = ent_rd_r.count;
            res_nxt.total_errors = ent_rd_r.errors;
            res_nxt.total_ms     = ent_rd_r.ms;
            ent_we    = 1'b1;
            ecur_nxt  = ei_r;
            bcur_nxt  = '0;
            hdr_nxt   = 1'b1;
            look_nxt  = 1'b1;
            bi_nxt    = '0;
            state_nxt = ST_DBASE;
          end else begin
            state_nxt = ST_DOUT;
          end
        end else begin
          // A skipped entry still loses any stray errors and sum.
          if (!look_r) ent_we = 1'b1;
          ei_nxt    = ei_r + (EW+1)'(1);
          state_nxt = ST_EISSUE;
        end
      end

      ST_DOUT: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DOUT);
  assign out_data  = res_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.record_kind == KIND_DONE)) |-> out_data.last)
    else $error("nothing-left record without last");

  a_last_resets_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |-> ((ecur_r == '0) && (bcur_r == '0)))
    else $error("cursors not reset at end of snapshot");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> ((ecur_r <= (EW+1)'(NUM_ENTRIES)) && (bcur_r <= (BW+1)'(BPE))))
    else $error("drain cursor out of range");

endmodule
